// ===== src/ipv4fke_pkg.sv =====
// Package for the IPv4 flow key extractor: item types, status codes and header offsets.
package ipv4fke_pkg;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_IPV4  = 2'd1,
		STATUS_BAD_IHL   = 2'd2,
		STATUS_TRUNCATED = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [15:0] frame_length;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] src_address;
		logic [31:0] dst_address;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic [15:0] wire_length;
	} out_item_t;

	localparam logic [6:0]  POS_MAX        = 7'd127;
	localparam logic [6:0]  POS_ETYPE_HI   = 7'd12;
	localparam logic [6:0]  POS_ETYPE_LO   = 7'd13;
	localparam logic [6:0]  POS_VER_IHL    = 7'd14;
	localparam logic [6:0]  POS_PROTO      = 7'd23;
	localparam logic [6:0]  POS_SRC_FIRST  = 7'd26;
	localparam logic [6:0]  POS_SRC_LAST   = 7'd29;
	localparam logic [6:0]  POS_DST_FIRST  = 7'd30;
	localparam logic [6:0]  POS_DST_LAST   = 7'd33;
	localparam logic [6:0]  LEN_ETH_HDR    = 7'd14;
	localparam logic [6:0]  LEN_VER_IHL    = 7'd15;
	localparam logic [6:0]  LEN_MIN_IP     = 7'd34;
	localparam logic [3:0]  IHL_MIN        = 4'd5;
	localparam logic [3:0]  IHL_MASK       = 4'hf;
	localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [7:0]  PORT_BYTES    = 8'd4;

endpackage

// ===== src/ipv4_flow_key_extractor.sv =====
// IPv4 flow key extractor: parses Ethernet frame bytes into a five-tuple result.
// Takes one frame byte per cycle, back to back while byte_stall is low, from the
// destination MAC onward. Each byte transfer updates the header capture registers in
// the same cycle; the byte that carries last_byte loads the result register, or the skid
// stage when the result register still holds an untaken result. This one-entry skid stage
// behind the result register keeps byte transfers going while a result waits; byte_stall
// rises only when both hold an untaken result. Status is ok, not IPv4, bad header length
// or truncated; on any error the tuple fields read zero and wire_length still carries the
// length sampled with the first byte. Bytes at position 127 and beyond of a frame are ignored.
module ipv4_flow_key_extractor (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  ipv4fke_pkg::in_item_t  byte_item,
	output logic                   key_valid,
	input  logic                   key_stall,
	output ipv4fke_pkg::out_item_t key_item
);

	logic [6:0]  pos_q;
	logic [15:0] etype_q;
	logic [3:0]  ihl_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [15:0] len_q;

	logic [6:0]  pos_e, pos_n;
	logic [15:0] etype_e, etype_n;
	logic [3:0]  ihl_e, ihl_n;
	logic [7:0]  proto_e, proto_n;
	logic [31:0] src_e, src_n;
	logic [31:0] dst_e, dst_n;
	logic [15:0] sport_e, sport_n;
	logic [15:0] dport_e, dport_n;
	logic [15:0] len_n;
	logic [7:0]  port_at;
	logic [7:0]  port_end;
	logic [7:0]  pos_w;
	logic        l4;
	ipv4fke_pkg::status_t   status;
	ipv4fke_pkg::out_item_t result;

	logic                   out_valid_q;
	ipv4fke_pkg::out_item_t out_q;
	logic                   skid_valid_q;
	ipv4fke_pkg::out_item_t skid_q;

	logic accept;
	logic produce;
	logic take;

	assign byte_stall = skid_valid_q;
	assign accept     = byte_valid && !byte_stall;
	assign produce    = accept && byte_item.last_byte;
	assign take       = out_valid_q && !key_stall;
	assign key_valid  = out_valid_q;
	assign key_item   = out_q;

	always_comb begin
		if (byte_item.first_byte) begin
			pos_e   = '0;
			etype_e = '0;
			ihl_e   = '0;
			proto_e = '0;
			src_e   = '0;
			dst_e   = '0;
			sport_e = '0;
			dport_e = '0;
			len_n   = byte_item.frame_length;
		end else begin
			pos_e   = pos_q;
			etype_e = etype_q;
			ihl_e   = ihl_q;
			proto_e = proto_q;
			src_e   = src_q;
			dst_e   = dst_q;
			sport_e = sport_q;
			dport_e = dport_q;
			len_n   = len_q;
		end

		pos_n   = pos_e;
		etype_n = etype_e;
		ihl_n   = ihl_e;
		proto_n = proto_e;
		src_n   = src_e;
		dst_n   = dst_e;
		sport_n = sport_e;
		dport_n = dport_e;
		pos_w   = {1'b0, pos_e};
		port_at = 8'd14 + {2'b00, ihl_e, 2'b00};

		if (pos_e != ipv4fke_pkg::POS_MAX) begin
			if (pos_e == ipv4fke_pkg::POS_ETYPE_HI || pos_e == ipv4fke_pkg::POS_ETYPE_LO)
				etype_n = {etype_e[7:0], byte_item.data_byte};
			if (pos_e == ipv4fke_pkg::POS_VER_IHL)
				ihl_n = byte_item.data_byte[3:0] & ipv4fke_pkg::IHL_MASK;
			if (pos_e == ipv4fke_pkg::POS_PROTO)
				proto_n = byte_item.data_byte;
			if (pos_e >= ipv4fke_pkg::POS_SRC_FIRST && pos_e <= ipv4fke_pkg::POS_SRC_LAST)
				src_n = {src_e[23:0], byte_item.data_byte};
			if (pos_e >= ipv4fke_pkg::POS_DST_FIRST && pos_e <= ipv4fke_pkg::POS_DST_LAST)
				dst_n = {dst_e[23:0], byte_item.data_byte};
			if (ihl_e >= ipv4fke_pkg::IHL_MIN && pos_w >= port_at
			    && pos_w < port_at + ipv4fke_pkg::PORT_BYTES) begin
				if (pos_w < port_at + 8'd2)
					sport_n = {sport_e[7:0], byte_item.data_byte};
				else
					dport_n = {dport_e[7:0], byte_item.data_byte};
			end
			pos_n = pos_e + 7'd1;
		end

		// end-of-frame checks against the updated captures
		port_end = 8'd14 + {2'b00, ihl_n, 2'b00} + ipv4fke_pkg::PORT_BYTES;
		l4 = proto_n == ipv4fke_pkg::PROTO_TCP || proto_n == ipv4fke_pkg::PROTO_UDP;
		if (pos_n < ipv4fke_pkg::LEN_ETH_HDR)
			status = ipv4fke_pkg::STATUS_TRUNCATED;
		else if (etype_n != ipv4fke_pkg::ETYPE_IPV4)
			status = ipv4fke_pkg::STATUS_NOT_IPV4;
		else if (pos_n < ipv4fke_pkg::LEN_VER_IHL)
			status = ipv4fke_pkg::STATUS_TRUNCATED;
		else if (ihl_n < ipv4fke_pkg::IHL_MIN)
			status = ipv4fke_pkg::STATUS_BAD_IHL;
		else if (pos_n < ipv4fke_pkg::LEN_MIN_IP)
			status = ipv4fke_pkg::STATUS_TRUNCATED;
		else if (l4 && {1'b0, pos_n} < port_end)
			status = ipv4fke_pkg::STATUS_TRUNCATED;
		else
			status = ipv4fke_pkg::STATUS_OK;

		result.status      = status;
		result.src_address = (status == ipv4fke_pkg::STATUS_OK) ? src_n : '0;
		result.dst_address = (status == ipv4fke_pkg::STATUS_OK) ? dst_n : '0;
		result.src_port    = (status == ipv4fke_pkg::STATUS_OK && l4) ? sport_n : '0;
		result.dst_port    = (status == ipv4fke_pkg::STATUS_OK && l4) ? dport_n : '0;
		result.protocol    = (status == ipv4fke_pkg::STATUS_OK) ? proto_n : '0;
		result.wire_length = len_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			ihl_q   <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
			len_q   <= '0;
		end else if (accept) begin
			len_q <= len_n;
			if (byte_item.last_byte) begin
				pos_q   <= '0;
				etype_q <= '0;
				ihl_q   <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				pos_q   <= pos_n;
				etype_q <= etype_n;
				ihl_q   <= ihl_n;
				proto_q <= proto_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
				sport_q <= sport_n;
				dport_q <= dport_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (produce) begin
			if (!out_valid_q || take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (take) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			if (!out_valid_q || take)
				out_q <= result;
			else
				skid_q <= result;
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_rise_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(key_valid) |-> $past(byte_valid && !byte_stall && byte_item.last_byte))
		else $error("result appeared without a last byte transfer");

	a_error_zero_tuple: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_item.status != ipv4fke_pkg::STATUS_OK
		|-> key_item.src_address == '0 && key_item.dst_address == '0
		    && key_item.protocol == '0 && key_item.src_port == '0)
		else $error("error result carries nonzero tuple fields");

	a_ports_only_l4: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_item.protocol != ipv4fke_pkg::PROTO_TCP
		&& key_item.protocol != ipv4fke_pkg::PROTO_UDP
		|-> key_item.src_port == '0 && key_item.dst_port == '0)
		else $error("nonzero ports for a protocol other than TCP or UDP");

endmodule
